>>> rtl/tme_pkg.sv
// tape machine executor package: request/response payload types, opcodes, status codes
// used by every file of the block; no dependencies
package tme_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_OUT   = 3'd2;
  localparam logic [2:0] OP_IN    = 3'd3;
  localparam logic [2:0] OP_RIGHT = 3'd4;
  localparam logic [2:0] OP_LEFT  = 3'd5;
  localparam logic [2:0] OP_BZ    = 3'd6;
  localparam logic [2:0] OP_BNZ   = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_UNF   = 2'd2;
  localparam logic [1:0] ST_HALT  = 2'd3;

  localparam int          LIMIT_W   = 11;
  localparam logic [10:0] LIMIT_RST = 11'd1024;
  localparam int          NPC_W     = 13;
  localparam int          TGT_W     = 12;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] jump_target;
    logic [7:0]  input_byte;
  } tme_req_t;

  typedef struct packed {
    logic [12:0] next_pc;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [1:0]  status;
  } tme_rsp_t;

  // rotation of the tape ring by one position
  typedef struct packed {
    logic fwd;
    logic back;
  } tme_shift_t;

endpackage

>>> rtl/tape_machine_executor.sv
// tape machine executor top level: ring of tape cells, execute unit, output skid stage
// depends on tme_pkg, tme_cell, tme_exec
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one decoded instruction per
//   transfer. rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result
//   per instruction, in order. cfg channel (cfg_valid / cfg_ready / cfg_data) writes
//   tape_limit; cfg_ready is always high, write only while the block is idle.
// Output: a result is registered into rsp, or into the skid entry if rsp is stalled.
// Throughput: one instruction per cycle while req_stall is low. The tape is a ring of
//   TAPE_DEPTH byte cells that rotates with the head, so the cell under the head always
//   sits at ring position 0 and each instruction is one read-modify-write of that cell.
// Stall: results go to an output register backed by one skid entry; req_stall
//   rises only when both hold a result, so at most two results wait on rsp_stall.
// Reset: rst clears every tape cell, head, program counter, halt flag and both
//   output entries, and restores tape_limit to 1024. After a pointer error every
//   further instruction returns status halted until reset.
module tape_machine_executor #(
  parameter int TAPE_DEPTH = 1024,
  parameter int PROG_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tme_pkg::tme_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tme_pkg::tme_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [10:0]       cfg_data
);
  import tme_pkg::*;

  logic [7:0]  ring [TAPE_DEPTH];
  tme_shift_t  shift;
  logic        load;
  logic [7:0]  load_data;
  tme_rsp_t    result;
  logic        accept;
  logic        take;

  tme_rsp_t    skid;
  logic        skid_valid;

  assign cfg_ready = 1'b1;
  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;
  assign take      = rsp_valid && !rsp_stall;

  tme_exec #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .accept    (accept),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .head_cell (ring[0]),
    .shift     (shift),
    .load      (load),
    .load_data (load_data),
    .result    (result)
  );

  for (genvar i = 0; i < TAPE_DEPTH; i++) begin : g_ring
    if (i == 0) begin : g_head
      tme_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .load      (load),
        .load_data (load_data),
        .from_next (ring[(i + 1) % TAPE_DEPTH]),
        .from_prev (ring[(i + TAPE_DEPTH - 1) % TAPE_DEPTH]),
        .value     (ring[i])
      );
    end else begin : g_body
      tme_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .load      (1'b0),
        .load_data (8'd0),
        .from_next (ring[(i + 1) % TAPE_DEPTH]),
        .from_prev (ring[(i + TAPE_DEPTH - 1) % TAPE_DEPTH]),
        .value     (ring[i])
      );
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          rsp_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (rsp_valid && !take) begin
          skid_valid <= 1'b1;
        end else begin
          rsp_valid <= 1'b1;
        end
      end else if (take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        rsp <= skid;
      end
    end else if (accept) begin
      if (rsp_valid && !take) begin
        skid <= result;
      end else begin
        rsp <= result;
      end
    end
  end

endmodule

>>> rtl/tme_cell.sv
// one byte of the tape ring; takes load_data when loaded, else its neighbor's value when the ring rotates
// depends on tme_pkg
module tme_cell (
  input  logic                clk,
  input  logic                rst,
  input  tme_pkg::tme_shift_t shift,
  input  logic                load,
  input  logic [7:0]          load_data,
  input  logic [7:0]          from_next,
  input  logic [7:0]          from_prev,
  output logic [7:0]          value
);
  import tme_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (load) begin
      value <= load_data;
    end else if (shift.fwd) begin
      value <= from_next;
    end else if (shift.back) begin
      value <= from_prev;
    end
  end

endmodule

>>> rtl/tme_exec.sv
// instruction execute unit: head, program counter, halt flag, tape limit register
// works on the cell under the head (ring position 0); depends on tme_pkg
module tme_exec #(
  parameter int TAPE_DEPTH = 1024,
  parameter int PROG_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  tme_pkg::tme_req_t   req,
  input  logic                accept,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data,
  input  logic [7:0]          head_cell,
  output tme_pkg::tme_shift_t shift,
  output logic                load,
  output logic [7:0]          load_data,
  output tme_pkg::tme_rsp_t   result
);
  import tme_pkg::*;

  localparam int HEAD_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int DW     = $clog2(TAPE_DEPTH + 1);
  localparam int CMP_W  = (DW > LIMIT_W) ? DW : LIMIT_W;
  localparam int PC_W   = $clog2(PROG_DEPTH + 1);
  localparam int SAT_W  = ((PC_W > NPC_W) ? PC_W : NPC_W) + 1;

  logic [HEAD_W-1:0]  head;
  logic [HEAD_W-1:0]  head_next;
  logic [PC_W-1:0]    pc;
  logic               halted;
  logic [LIMIT_W-1:0] tape_limit;

  logic [CMP_W-1:0]   limit_c;
  logic [CMP_W-1:0]   head_inc;
  logic [SAT_W-1:0]   pc_wide;
  logic [SAT_W-1:0]   npc;
  logic [1:0]         status;
  logic               ov;
  logic [7:0]         ob;
  logic               ld;
  logic               sh_fwd;
  logic               sh_back;

  function automatic logic [SAT_W-1:0] sat_pc(input logic [SAT_W-1:0] v);
    logic [SAT_W-1:0] top_pc;
    top_pc = SAT_W'(PROG_DEPTH);
    return (v > top_pc) ? top_pc : v;
  endfunction

  assign limit_c  = (CMP_W'(tape_limit) > CMP_W'(TAPE_DEPTH)) ? CMP_W'(TAPE_DEPTH)
                                                               : CMP_W'(tape_limit);
  assign head_inc = CMP_W'(head) + CMP_W'(1);
  assign pc_wide  = SAT_W'(pc);

  always_comb begin
    npc       = sat_pc(pc_wide + SAT_W'(1));
    status    = ST_OK;
    ov        = 1'b0;
    ob        = '0;
    ld        = 1'b0;
    load_data = head_cell;
    sh_fwd    = 1'b0;
    sh_back   = 1'b0;
    head_next = head;
    if (halted) begin
      status = ST_HALT;
      npc    = pc_wide;
    end else begin
      case (req.req_type)
        OP_ADD: begin
          ld        = 1'b1;
          load_data = head_cell + 8'd1;
        end
        OP_SUB: begin
          ld        = 1'b1;
          load_data = head_cell - 8'd1;
        end
        OP_OUT: begin
          ov = 1'b1;
          ob = head_cell;
        end
        OP_IN: begin
          ld        = 1'b1;
          load_data = req.input_byte;
        end
        OP_RIGHT: begin
          if (head_inc >= limit_c) begin
            status = ST_OVF;
          end else begin
            sh_fwd    = 1'b1;
            head_next = head + HEAD_W'(1);
          end
        end
        OP_LEFT: begin
          if (head == '0) begin
            status = ST_UNF;
          end else begin
            sh_back   = 1'b1;
            head_next = head - HEAD_W'(1);
          end
        end
        OP_BZ: begin
          if (head_cell == 8'd0) begin
            npc = sat_pc(SAT_W'(req.jump_target) + SAT_W'(1));
          end
        end
        OP_BNZ: begin
          if (head_cell != 8'd0) begin
            npc = sat_pc(SAT_W'(req.jump_target) + SAT_W'(1));
          end
        end
        default: begin
        end
      endcase
      // pointer error: head, pc and tape stay as they are, report the held pc
      if (status != ST_OK) begin
        npc = pc_wide;
      end
    end
  end

  assign result.next_pc   = npc[NPC_W-1:0];
  assign result.out_valid = ov;
  assign result.out_byte  = ob;
  assign result.status    = status;

  assign shift.fwd  = accept && sh_fwd;
  assign shift.back = accept && sh_back;
  assign load       = accept && ld;

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      pc         <= '0;
      halted     <= 1'b0;
      tape_limit <= LIMIT_RST;
    end else begin
      if (cfg_we) begin
        tape_limit <= cfg_data;
      end
      if (accept && !halted) begin
        if (status != ST_OK) begin
          halted <= 1'b1;
        end else begin
          pc   <= npc[PC_W-1:0];
          head <= head_next;
        end
      end
    end
  end

endmodule

>>> rtl/tme_checker.sv
// port-level checks for the tape machine executor, bound to the top level
// depends on tme_pkg and tape_machine_executor
module tme_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input tme_pkg::tme_rsp_t rsp
);
  import tme_pkg::*;

  // a stalled result holds until its transfer
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // reset empties both output entries
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("output not empty after reset");

  // with nothing pending, a request transfer shows its result next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !rsp_valid |=> rsp_valid)
    else $error("result missing one cycle after request");

  // requests are held off only while results wait
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("req_stall without a pending result");

endmodule

bind tape_machine_executor tme_checker u_tme_checker (.*);

>>> test/tb_tme_pkg.sv
// testbench package for the tape machine executor: tape scoreboard class
// depends on tme_pkg for the request/response types, opcodes and status codes
`timescale 1ns / 1ps

package tb_tme_pkg;
  import tme_pkg::*;

  localparam int TAPE_CELLS = 1024;
  localparam int PROG_END   = 4096;
  localparam int CELL_BITS  = $clog2(TAPE_CELLS);

  class tape_scoreboard;
    logic [7:0]  tape [TAPE_CELLS];
    int unsigned head;
    int unsigned pc;
    bit          halted;
    int unsigned limit;
    tme_rsp_t    expected_results [$];
    int unsigned mismatches;

    function new();
      foreach (tape[i]) tape[i] = '0;
      head       = 0;
      pc         = 0;
      halted     = 1'b0;
      limit      = 32'(LIMIT_RST);
      mismatches = 0;
    endfunction

    function void set_limit(logic [10:0] value);
      limit = 32'(value);
    endfunction

    function int unsigned clamp_pc(int unsigned value);
      return (value > PROG_END) ? PROG_END : value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // executes one accepted instruction on the shadow state
    function void predict_instruction(tme_req_t r);
      tme_rsp_t             res;
      int unsigned          bound;
      int unsigned          h;
      int unsigned          npc;
      logic [1:0]           st;
      logic [CELL_BITS-1:0] idx;
      res = '0;
      if (halted) begin
        res.next_pc = pc[12:0];
        res.status  = ST_HALT;
        expected_results.push_back(res);
        return;
      end
      bound = (limit > TAPE_CELLS) ? TAPE_CELLS : limit;
      h     = head;
      idx   = h[CELL_BITS-1:0];
      npc   = clamp_pc(pc + 1);
      st    = ST_OK;
      case (r.req_type)
        OP_ADD: tape[idx] = tape[idx] + 8'd1;
        OP_SUB: tape[idx] = tape[idx] - 8'd1;
        OP_OUT: begin
          res.out_valid = 1'b1;
          res.out_byte  = tape[idx];
        end
        OP_IN: tape[idx] = r.input_byte;
        OP_RIGHT: begin
          if (h + 1 >= bound) st = ST_OVF;
          else h = h + 1;
        end
        OP_LEFT: begin
          if (h == 0) st = ST_UNF;
          else h = h - 1;
        end
        OP_BZ: begin
          if (tape[idx] == 8'd0) npc = clamp_pc(r.jump_target + 1);
        end
        default: begin
          if (tape[idx] != 8'd0) npc = clamp_pc(r.jump_target + 1);
        end
      endcase
      if (st != ST_OK) begin
        // pointer error: nothing moves, block halts
        halted      = 1'b1;
        res         = '0;
        res.next_pc = pc[12:0];
        res.status  = st;
      end else begin
        head        = h;
        pc          = npc;
        res.next_pc = npc[12:0];
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(tme_rsp_t got);
      tme_rsp_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: next_pc=%0d out_valid=%0b out_byte=%02h status=%0d",
                   got.next_pc, got.out_valid, got.out_byte, got.status);
        return;
      end
      want = expected_results.pop_front();
      if (got.next_pc !== want.next_pc || got.out_valid !== want.out_valid ||
          got.out_byte !== want.out_byte || got.status !== want.status) begin
        mismatches++;
        // fields in order next_pc / out_valid / out_byte / status
        if (mismatches <= 10)
          $display("result mismatch: expected %0d/%0b/%02h/%0d, got %0d/%0b/%02h/%0d",
                   want.next_pc, want.out_valid, want.out_byte, want.status,
                   got.next_pc, got.out_valid, got.out_byte, got.status);
      end
    endfunction
  endclass

endpackage

>>> test/tb_top.sv
// top-level testbench for tape_machine_executor: directed and random instruction streams
// with random idling on both channels; depends on tme_pkg, tb_tme_pkg and the block's RTL
`timescale 1ns / 1ps

module tb_top;
  import tme_pkg::*;
  import tb_tme_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  tme_req_t    req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  tme_rsp_t    rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data  = '0;

  tape_scoreboard sb;
  int unsigned    idle_cycles = 0;
  bit             quiet       = 1'b0;
  int             gen_head    = 0;
  int             gen_limit   = TAPE_CELLS;

  tape_machine_executor #(
    .TAPE_DEPTH(TAPE_CELLS),
    .PROG_DEPTH(PROG_END)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (req_valid && !req_stall) sb.predict_instruction(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : rsp_backpressure
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < 12) begin
        n = $urandom_range(1, 10);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender holds off until every result is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [10:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_limit = (value > TAPE_CELLS) ? TAPE_CELLS : int'(value);
  endtask

  task automatic send_req(input tme_req_t r);
    int n;
    if (!quiet && $urandom_range(0, 199) == 0) begin
      wait_drained();
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 10);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    // track the head the way a legal move changes it
    if (r.req_type == OP_RIGHT && gen_head + 1 < gen_limit) gen_head++;
    if (r.req_type == OP_LEFT && gen_head > 0) gen_head--;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [11:0] target,
                         input logic [7:0] data);
    tme_req_t r;
    r.req_type    = op;
    r.jump_target = target;
    r.input_byte  = data;
    send_req(r);
  endtask

  // random instruction that never causes a pointer error
  task automatic next_random(output tme_req_t r);
    int pick;
    pick          = $urandom_range(0, 99);
    r.jump_target = 12'($urandom_range(0, 4095));
    r.input_byte  = 8'($urandom_range(0, 255));
    if (pick < 16)      r.req_type = OP_ADD;
    else if (pick < 30) r.req_type = OP_SUB;
    else if (pick < 42) r.req_type = OP_IN;
    else if (pick < 56) r.req_type = OP_OUT;
    else if (pick < 72) r.req_type = OP_RIGHT;
    else if (pick < 84) r.req_type = OP_LEFT;
    else if (pick < 92) r.req_type = OP_BZ;
    else                r.req_type = OP_BNZ;
    if (r.req_type == OP_RIGHT && gen_head + 1 >= gen_limit)
      r.req_type = (gen_head > 0) ? OP_LEFT : OP_ADD;
    else if (r.req_type == OP_LEFT && gen_head == 0)
      r.req_type = (gen_head + 1 < gen_limit) ? OP_RIGHT : OP_SUB;
  endtask

  initial begin : stimulus
    tme_req_t    r;
    logic [10:0] phase_limit [7];
    int          finale;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // limit above the store clamps to the tape size
    write_limit(11'd2047);
    send_op(OP_OUT, 12'd0, 8'h00);
    send_op(OP_ADD, 12'd0, 8'h00);
    send_op(OP_OUT, 12'd0, 8'h00);
    send_op(OP_SUB, 12'd0, 8'h00);
    send_op(OP_SUB, 12'd0, 8'h00);
    send_op(OP_OUT, 12'd0, 8'h00);
    send_op(OP_ADD, 12'd0, 8'h00);
    send_op(OP_IN, 12'd0, 8'hff);
    send_op(OP_ADD, 12'd0, 8'h00);
    send_op(OP_BZ, 12'd4095, 8'h00);
    // program counter stays saturated at the end of program
    send_op(OP_ADD, 12'd0, 8'h00);
    send_op(OP_BNZ, 12'd4094, 8'h00);
    send_op(OP_BNZ, 12'd0, 8'h00);
    send_op(OP_IN, 12'd0, 8'ha5);
    send_op(OP_BZ, 12'd100, 8'h00);
    send_op(OP_RIGHT, 12'd0, 8'h00);
    send_op(OP_OUT, 12'd0, 8'h00);
    send_op(OP_BZ, 12'd4095, 8'h00);
    send_op(OP_BNZ, 12'd7, 8'h00);
    send_op(OP_LEFT, 12'd0, 8'h00);
    send_op(OP_OUT, 12'd0, 8'h00);
    send_op(OP_IN, 12'd0, 8'h00);
    send_op(OP_OUT, 12'd0, 8'h00);

    phase_limit[0] = 11'd1024;
    phase_limit[1] = 11'd2;
    phase_limit[2] = 11'd0;
    phase_limit[3] = 11'd1;
    phase_limit[4] = 11'd1025;
    phase_limit[5] = 11'($urandom_range(3, 64));
    phase_limit[6] = 11'($urandom_range(0, 2047));
    foreach (phase_limit[p]) begin
      write_limit(phase_limit[p]);
      repeat (65) begin
        next_random(r);
        send_req(r);
      end
    end

    // last stretch runs without idling on either side
    write_limit(11'($urandom_range(3, 2047)));
    quiet = 1'b1;
    repeat (60) begin
      next_random(r);
      send_req(r);
    end

    // one pointer error halts the block for the rest of the run
    finale = $urandom_range(0, 2);
    if (finale == 0) begin
      while (gen_head > 0) send_op(OP_LEFT, 12'($urandom_range(0, 4095)), 8'hc3);
      send_op(OP_LEFT, 12'($urandom_range(0, 4095)), 8'h3c);
    end else begin
      if (finale == 1) write_limit(11'($urandom_range(2, 40)));
      else             write_limit(11'($urandom_range(0, 1)));
      while (gen_head + 1 < gen_limit) begin
        if ($urandom_range(0, 3) == 0) send_op(OP_ADD, 12'd0, 8'h00);
        send_op(OP_RIGHT, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
      end
      send_op(OP_RIGHT, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    end
    repeat (20) begin
      r.req_type    = 3'($urandom_range(0, 7));
      r.jump_target = 12'($urandom_range(0, 4095));
      r.input_byte  = 8'($urandom_range(0, 255));
      send_req(r);
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
rtl/tme_pkg.sv
rtl/tme_cell.sv
rtl/tme_exec.sv
rtl/tape_machine_executor.sv
rtl/tme_checker.sv
test/tb_tme_pkg.sv
test/tb_top.sv
